>>> sv/multiplexed_seven_segment_scanner_unit_assert.svh
// Assertion macros shared by the display scanner checker.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_UNIT_ASSERT_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MSSS_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MSSS_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

>>> sv/msss_pkg.sv
// Shared types, constants and decode functions for the display scanner.
`default_nettype none

package msss_pkg;

    // Item commands carried in s_tuser
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_DECIMAL = 2'd1,
        CMD_BAR     = 2'd2
    } cmd_t;

    localparam logic [2:0]  BAR_POSITION = 3'd4;
    localparam logic [13:0] VALUE_MAX    = 14'd9999;
    localparam logic [7:0]  DOT_BIT      = 8'h80;
    localparam logic [7:0]  BAR_RESET    = 8'hF0;

    // Active-low segment code of one decimal digit
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = 8'hFF;
        endcase
        return code;
    endfunction

    // Leading digit of value for one decimal weight; parallel compares
    // against the multiples of the weight, value below ten times weight
    function automatic logic [3:0] dec_digit(input logic [13:0] value,
                                             input logic [13:0] weight);
        logic [3:0] d;
        d = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (value >= 14'(k) * weight)
            begin
                d = 4'(k);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

>>> sv/multiplexed_seven_segment_scanner_unit.sv
// Scanner for a four-digit seven-segment display with an eight-LED bar.
//
// Input stream s_*: s_tuser carries the command (tick, load decimal, load
// bar); s_tdata carries the decimal value and the bar pattern. Load beats
// update the stored patterns and produce no output. Each tick beat
// produces one output beat on m_*: the segment byte, the digit enables,
// the bar enable and the scan position driven, stepping 0..3 then 4 (bar).
// cfg_wen/cfg_wdata set the digit that lights its decimal point.
//
// An accepted tick beat passes the input register, then the result register,
// before its output beat. Throughput: one beat per cycle while the receiver
// does not stall; the thousands and hundreds split runs ahead of the input
// register, and the tens split and segment lookup run ahead of the digit store.
// A stalled receiver holds the output beat; one further beat waits in the
// input register, and load beats keep flowing past a held output beat.
//
// Reset: the digits show "0123", bar pattern F0 hex, scan position 0,
// decimal point on digit 0, both stages empty.
`default_nettype none

module multiplexed_seven_segment_scanner_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // decimal_value[13:0], bar_pattern[21:14], zero
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // master side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // segment_lines[7:0], digit_enables_n[11:8],
                                        // bar_enable_n[12], scan_step[15:13]
    // configuration
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_wdata  // dot_position
);
    import msss_pkg::*;

    // input stage
    logic        in_valid_reg, in_valid_next;
    logic [1:0]  in_cmd_reg;
    logic [3:0]  in_thou_reg;
    logic [3:0]  in_hund_reg;
    logic [6:0]  in_rest_reg;
    logic [7:0]  in_bar_reg;

    // capture-side split
    logic [13:0] value_sat;
    logic [3:0]  thou;
    logic [9:0]  rem_thou;
    logic [3:0]  hund;
    logic [6:0]  rem_hund;
    logic        s_accept;

    // display state
    logic [7:0]  digit_reg [4];
    logic [7:0]  bar_store_reg;
    logic [2:0]  scan_pos_reg, scan_pos_next;
    logic [2:0]  dot_pos_reg;

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  seg_reg, seg_next;
    logic [3:0]  dig_n_reg, dig_n_next;
    logic        bar_n_reg, bar_n_next;
    logic [2:0]  step_reg, step_next;

    logic        out_free;
    logic        advance;
    logic        is_tick;
    logic [3:0]  tens;
    logic [3:0]  ones;

    // Split the saturated value into thousands, hundreds and the rest
    always_comb
    begin
        value_sat = (s_tdata[13:0] > VALUE_MAX) ? VALUE_MAX : s_tdata[13:0];
        thou      = dec_digit(value_sat, 14'd1000);
        rem_thou  = 10'(value_sat - 14'(thou) * 14'd1000);
        hund      = dec_digit(14'(rem_thou), 14'd100);
        rem_hund  = 7'(rem_thou - 10'(hund) * 10'd100);
    end

    // Handshake: the input stage moves on unless a tick meets a full output that is not taken
    assign is_tick  = (in_cmd_reg == CMD_TICK);
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!is_tick || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // Hold the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_cmd_reg  <= s_tuser;
            in_thou_reg <= thou;
            in_hund_reg <= hund;
            in_rest_reg <= rem_hund;
            in_bar_reg  <= s_tdata[21:14];
        end
    end

    // Finish the split: tens and ones of the rest below one hundred
    always_comb
    begin
        tens = dec_digit(14'(in_rest_reg), 14'd10);
        ones = 4'(in_rest_reg - 7'(tens) * 7'd10);
    end

    // Drive the current scan position and advance it
    always_comb
    begin
        seg_next      = seg_reg;
        dig_n_next    = dig_n_reg;
        bar_n_next    = bar_n_reg;
        step_next     = step_reg;
        scan_pos_next = scan_pos_reg;
        if (advance && is_tick)
        begin
            if (scan_pos_reg >= BAR_POSITION)
            begin
                seg_next      = bar_store_reg;
                dig_n_next    = 4'hF;
                bar_n_next    = 1'b0;
                step_next     = BAR_POSITION;
                scan_pos_next = 3'd0;
            end
            else
            begin
                seg_next = digit_reg[scan_pos_reg[1:0]] | DOT_BIT;
                if (dot_pos_reg == scan_pos_reg)
                begin
                    seg_next = seg_next & ~DOT_BIT;
                end
                dig_n_next    = ~(4'b0001 << scan_pos_reg[1:0]);
                bar_n_next    = 1'b1;
                step_next     = scan_pos_reg;
                scan_pos_next = scan_pos_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        if (advance && is_tick)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Display state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg[0]  <= seg_code(4'd0);
            digit_reg[1]  <= seg_code(4'd1);
            digit_reg[2]  <= seg_code(4'd2);
            digit_reg[3]  <= seg_code(4'd3);
            bar_store_reg <= BAR_RESET;
            scan_pos_reg  <= 3'd0;
            dot_pos_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_pos_reg  <= scan_pos_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                dot_pos_reg <= cfg_wdata;
            end
            if (advance && (in_cmd_reg == CMD_DECIMAL))
            begin
                digit_reg[0] <= seg_code(in_thou_reg);
                digit_reg[1] <= seg_code(in_hund_reg);
                digit_reg[2] <= seg_code(tens);
                digit_reg[3] <= seg_code(ones);
            end
            if (advance && (in_cmd_reg == CMD_BAR))
            begin
                bar_store_reg <= in_bar_reg;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        seg_reg   <= seg_next;
        dig_n_reg <= dig_n_next;
        bar_n_reg <= bar_n_next;
        step_reg  <= step_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {step_reg, bar_n_reg, dig_n_reg, seg_reg};

endmodule

`default_nettype wire

>>> sv/msss_checker.sv
// Port-level checker for the display scanner, bound to the top level.
`default_nettype none
`include "multiplexed_seven_segment_scanner_unit_assert.svh"

module msss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    import msss_pkg::*;

    // held beat stays put
    `MSSS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output beat changed while stalled")

    // bar enabled exactly at the bar position
    `MSSS_ASSERT_NOW(a_bar_step, m_tvalid, (m_tdata[12] == 1'b0) == (m_tdata[15:13] == BAR_POSITION), "bar enable does not match scan step")

    // digit step enables exactly one digit
    `MSSS_ASSERT_NOW(a_one_digit, m_tvalid && m_tdata[12], $countones(m_tdata[11:8]) == 3, "digit step without exactly one enable")

    // bar step turns all digits off
    `MSSS_ASSERT_NOW(a_bar_dark, m_tvalid && !m_tdata[12], m_tdata[11:8] == 4'hF, "digit enabled on bar step")

endmodule

bind multiplexed_seven_segment_scanner_unit msss_checker u_msss_checker (.*);

`default_nettype wire
